// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level design file.
// No dependencies; take in by `include before the module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BPE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define BPE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BPE_ASSERT_IMPL(lbl, ante, cons, msg)
`define BPE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== design/bpe_pkg.sv =====
// Shared constants and types for the Bezier path evaluator.
// No dependencies.
package bpe_pkg;
    localparam int FRAC_BITS    = 16;
    localparam int MAX_SEGMENTS = 16;
    localparam int SEG_W        = $clog2(MAX_SEGMENTS);
    localparam int SLOT_COUNT   = 4 * MAX_SEGMENTS;
    localparam int ADDR_W       = $clog2(SLOT_COUNT);
    localparam int COORD_W      = 32;
    localparam int PT_W         = 3 * COORD_W;
    localparam int CNT_W        = 5;
    localparam int U_W          = FRAC_BITS + 1;
    localparam int W_W          = FRAC_BITS + 2;
    localparam int PROD_W       = W_W + 1 + COORD_W;
    localparam int ACC_W        = PROD_W + 2;
    localparam int SH_W         = ACC_W - FRAC_BITS;
    localparam int MAG_W        = COORD_W + 1;
    localparam int DIV_CNT_W    = $clog2(FRAC_BITS);
    localparam int S_DATA_W     = 136;
    localparam int M_DATA_W     = 104;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_EVAL  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CHK,
        ST_BASE_RD,
        ST_BASE_CHK,
        ST_DIV,
        ST_WGT1,
        ST_WGT2,
        ST_PT_RD,
        ST_PT_MUL,
        ST_PT_ACC,
        ST_OUT
    } state_t;
endpackage

// ===== design/bpe_ram.sv =====
// Generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
module bpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== design/bpe_div.sv =====
// Restoring divider: FRAC_BITS-bit fraction of num/den, one bit per cycle.
// Depends on bpe_pkg. Caller guarantees num < den.
module bpe_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [bpe_pkg::MAG_W-1:0]     num_mag,
    input  logic [bpe_pkg::MAG_W-1:0]     den_mag,
    output logic                          done,
    output logic [bpe_pkg::FRAC_BITS-1:0] quot
);
    import bpe_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [MAG_W-1:0]     rem_reg;
    logic [MAG_W-1:0]     den_reg;
    logic [FRAC_BITS-1:0] quot_reg;
    logic [MAG_W:0]       trial;
    logic                 fits;

    assign trial = {rem_reg, 1'b0};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(FRAC_BITS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= num_mag;
            den_reg  <= den_mag;
            quot_reg <= '0;
        end else if (busy_reg) begin
            rem_reg  <= fits ? MAG_W'(trial - {1'b0, den_reg}) : MAG_W'(trial);
            quot_reg <= {quot_reg[FRAC_BITS-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
endmodule

// ===== design/piecewise_cubic_bezier_eval.sv =====
// Top level: piecewise cubic Bezier path evaluator over a control-point RAM.
// Depends on bpe_pkg, bpe_ram, bpe_div and assert_macros.svh.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+------------------------------------
//   cfg      | in  | cfg_wr_en          | cfg_wr_data = segment_count
//   s        | in  | s_tvalid/s_tready  | s_tuser = kind, s_tdata = point/t
//   m        | out | m_tvalid/m_tready  | m_tdata = x, y, z, segment_used
//
// An evaluate transfer searches the segments with one RAM read per
// segment end, then runs the bit-serial divider when it is needed.
// Reset is synchronous, active low; RAM contents are not cleared.
// The result sits in an output register, so a new transfer is taken while
// the previous result still waits on m_tready.
`include "assert_macros.svh"
module piecewise_cubic_bezier_eval (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [bpe_pkg::CNT_W-1:0]    cfg_wr_data,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // s_tdata: point_index[5:0], point_x[37:6], point_y[69:38],
    //          point_z[101:70], eval_t[133:102], zero pad[135:134]
    input  logic [bpe_pkg::S_DATA_W-1:0] s_tdata,
    // s_tuser: kind
    input  logic                         s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // m_tdata: curve_x[31:0], curve_y[63:32], curve_z[95:64],
    //          segment_used[99:96], zero pad[103:100]
    output logic [bpe_pkg::M_DATA_W-1:0] m_tdata
);
    import bpe_pkg::*;

    localparam logic [U_W-1:0] ONE = U_W'(1) << FRAC_BITS;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] seg_count_reg;

    // search / segment bookkeeping
    logic [SEG_W-1:0]          k_reg, last_reg, seg_reg;
    logic signed [COORD_W-1:0] t_reg, xe_reg;
    logic [1:0]                pos_reg;

    // blend datapath
    logic [U_W-1:0]            u_reg, v2_reg, u2_reg;
    logic [W_W-1:0]            w_reg [4];
    logic signed [PROD_W-1:0]  prod_reg [3];
    logic signed [ACC_W-1:0]   acc_reg [3];

    logic                      m_tvalid_reg;
    logic [M_DATA_W-1:0]       m_data_reg;

    // RAM
    logic                      ram_we, ram_re;
    logic [ADDR_W-1:0]         ram_raddr;
    logic [PT_W-1:0]           ram_rdata;

    // divider
    logic                      div_start, div_done;
    logic [FRAC_BITS-1:0]      div_q;

    logic                      accept;
    logic signed [COORD_W-1:0] rd_x;
    logic                      hit;
    logic [CNT_W-1:0]          cnt_eff;
    logic signed [MAG_W-1:0]   num, den;
    logic [MAG_W-1:0]          num_mag, den_mag;
    logic                      u_zero, u_one, need_div;
    logic [U_W-1:0]            v_val;
    logic [2*U_W-1:0]          vv, uu, p0, p1, p2, p3;
    logic signed [W_W:0]       w_s;
    logic out_load;
    logic signed [SH_W-1:0]    sh [3];
    logic [COORD_W-1:0]        sat [3];

    assign accept   = s_tvalid && s_tready;
    assign ram_we   = accept && (s_tuser == KIND_WRITE);
    assign rd_x     = ram_rdata[COORD_W-1:0];
    assign hit      = rd_x > t_reg;
    assign out_load = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    always_comb begin
        if (seg_count_reg == '0) begin
            cnt_eff = CNT_W'(1);
        end else if (seg_count_reg > CNT_W'(MAX_SEGMENTS)) begin
            cnt_eff = CNT_W'(MAX_SEGMENTS);
        end else begin
            cnt_eff = seg_count_reg;
        end
    end

    // normalization: num = t - xs, den = xe - xs
    assign num     = MAG_W'(t_reg) - MAG_W'(rd_x);
    assign den     = MAG_W'(xe_reg) - MAG_W'(rd_x);
    assign num_mag = num[MAG_W-1] ? MAG_W'(-num) : MAG_W'(num);
    assign den_mag = den[MAG_W-1] ? MAG_W'(-den) : MAG_W'(den);
    assign u_zero  = (num == '0) || (den == '0) || (num[MAG_W-1] != den[MAG_W-1]);
    assign u_one   = !u_zero && (num_mag >= den_mag);
    assign need_div = !u_zero && !u_one;

    // Bernstein weights, two registered multiply levels
    assign v_val = ONE - u_reg;
    assign vv    = (2*U_W)'(v_val) * (2*U_W)'(v_val);
    assign uu    = (2*U_W)'(u_reg) * (2*U_W)'(u_reg);
    assign p0    = (2*U_W)'(v2_reg) * (2*U_W)'(v_val);
    assign p1    = (2*U_W)'(v2_reg) * (2*U_W)'(u_reg);
    assign p2    = (2*U_W)'(u2_reg) * (2*U_W)'(v_val);
    assign p3    = (2*U_W)'(u2_reg) * (2*U_W)'(u_reg);

    assign w_s = signed'({1'b0, w_reg[pos_reg]});

    // floor shift and signed 32-bit saturation
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            sh[j] = SH_W'(acc_reg[j] >>> FRAC_BITS);
            if ((sh[j][SH_W-1:COORD_W-1] == '0) || (sh[j][SH_W-1:COORD_W-1] == '1)) begin
                sat[j] = sh[j][COORD_W-1:0];
            end else if (sh[j][SH_W-1]) begin
                sat[j] = {1'b1, {(COORD_W-1){1'b0}}};
            end else begin
                sat[j] = {1'b0, {(COORD_W-1){1'b1}}};
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (s_tuser == KIND_EVAL)) state_next = ST_SRCH_RD;
            end
            ST_SRCH_RD:  state_next = ST_SRCH_CHK;
            ST_SRCH_CHK: begin
                if (hit || (k_reg == last_reg)) state_next = ST_BASE_RD;
                else state_next = ST_SRCH_RD;
            end
            ST_BASE_RD:  state_next = ST_BASE_CHK;
            ST_BASE_CHK: state_next = need_div ? ST_DIV : ST_WGT1;
            ST_DIV: begin
                if (div_done) state_next = ST_WGT1;
            end
            ST_WGT1:     state_next = ST_WGT2;
            ST_WGT2:     state_next = ST_PT_RD;
            ST_PT_RD:    state_next = ST_PT_MUL;
            ST_PT_MUL:   state_next = ST_PT_ACC;
            ST_PT_ACC:   state_next = (pos_reg == 2'd3) ? ST_OUT : ST_PT_RD;
            ST_OUT: begin
                if (out_load) state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_tready  = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = '0;
        div_start = 1'b0;
        case (state_reg)
            ST_IDLE:     s_tready = 1'b1;
            ST_SRCH_RD: begin
                ram_re    = 1'b1;
                ram_raddr = {k_reg, 2'b11};
            end
            ST_BASE_RD: begin
                ram_re    = 1'b1;
                ram_raddr = {seg_reg, 2'b00};
            end
            ST_BASE_CHK: div_start = need_div;
            ST_PT_RD: begin
                ram_re    = 1'b1;
                ram_raddr = {seg_reg, pos_reg};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            seg_count_reg <= CNT_W'(1);
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) seg_count_reg <= cfg_wr_data;
            if (out_load) m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                t_reg    <= s_tdata[133:102];
                k_reg    <= '0;
                last_reg <= SEG_W'(cnt_eff - CNT_W'(1));
            end
            ST_SRCH_CHK: begin
                xe_reg  <= rd_x;
                seg_reg <= k_reg;
                k_reg   <= k_reg + 1'b1;
            end
            ST_BASE_CHK: u_reg <= u_one ? ONE : '0;
            ST_DIV: begin
                if (div_done) u_reg <= {1'b0, div_q};
            end
            ST_WGT1: begin
                v2_reg <= vv[2*FRAC_BITS:FRAC_BITS];
                u2_reg <= uu[2*FRAC_BITS:FRAC_BITS];
            end
            ST_WGT2: begin
                w_reg[0] <= W_W'(p0[2*FRAC_BITS:FRAC_BITS]);
                w_reg[1] <= {p1[2*FRAC_BITS:FRAC_BITS], 1'b0}
                            + W_W'(p1[2*FRAC_BITS:FRAC_BITS]);
                w_reg[2] <= {p2[2*FRAC_BITS:FRAC_BITS], 1'b0}
                            + W_W'(p2[2*FRAC_BITS:FRAC_BITS]);
                w_reg[3] <= W_W'(p3[2*FRAC_BITS:FRAC_BITS]);
                pos_reg  <= '0;
                for (int j = 0; j < 3; j++) acc_reg[j] <= '0;
            end
            ST_PT_MUL: begin
                for (int j = 0; j < 3; j++) begin
                    prod_reg[j] <= w_s * signed'(ram_rdata[j*COORD_W +: COORD_W]);
                end
            end
            ST_PT_ACC: begin
                for (int j = 0; j < 3; j++) begin
                    acc_reg[j] <= acc_reg[j] + ACC_W'(prod_reg[j]);
                end
                pos_reg <= pos_reg + 1'b1;
            end
            default: ;
        endcase
        if (out_load) begin
            m_data_reg <= {{(M_DATA_W-3*COORD_W-SEG_W){1'b0}}, seg_reg,
                           sat[2], sat[1], sat[0]};
        end
    end

    bpe_ram #(
        .WIDTH(PT_W),
        .DEPTH(SLOT_COUNT)
    ) u_points (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (s_tdata[ADDR_W-1:0]),
        .wdata (s_tdata[ADDR_W +: PT_W]),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bpe_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num_mag (num_mag),
        .den_mag (den_mag),
        .done    (div_done),
        .quot    (div_q)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

    `BPE_ASSERT_IMPL(a_wr_idle, ram_we, state_reg == ST_IDLE, "point write outside idle")
    `BPE_ASSERT_IMPL(a_k_bound, state_reg == ST_SRCH_CHK, k_reg <= last_reg, "search overran count")
    `BPE_ASSERT_IMPL(a_u_cap, state_reg == ST_WGT1, u_reg <= ONE, "normalized t above one")
    `BPE_ASSERT_NEXT(a_out_load, out_load, m_tvalid_reg, "result not presented")
endmodule
